FILE: design/sitoa_pkg.sv
// package for the signed integer to decimal ascii converter
// holds widths, character codes, state types and the result struct
// used by every module of the block and by its checker
package sitoa_pkg;

	// width of the signed input value
	localparam int VALUE_WIDTH = 32;

	// input tdata rounded up to whole bytes
	localparam int IN_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

	// decimal digits needed for any magnitude of VALUE_WIDTH bits
	// (1233 / 4096 is just below log10 of 2)
	localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int BCD_W      = NUM_DIGITS * 4;

	// counter widths
	localparam int SHIFT_CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int LEFT_CNT_W  = $clog2(NUM_DIGITS + 1);

	// character codes
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// converter sequencer
	typedef enum logic [1:0] {
		CV_IDLE,
		CV_SHIFT,
		CV_HOLD
	} conv_state_t;

	// character emitter sequencer
	typedef enum logic [1:0] {
		EM_IDLE,
		EM_SKIP,
		EM_SIGN,
		EM_DIGIT
	} emit_state_t;

	// finished conversion handed from converter to emitter
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic             neg;
	} conv_result_t;

endpackage

FILE: design/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text. Each input item is a two's-complement value of
// VALUE_WIDTH bits; the block sends its decimal text one character per output item, most
// significant first: '-' for a negative value, then the digits without leading zeros, or a
// single '0' for zero, with tlast on the final character. The most negative value converts
// exactly. A shift-and-add-3 converter takes one magnitude bit per cycle and accepts no new
// item until the emitter has taken its result. The emitter takes the result, drops leading
// zeros to find the first digit, then sends the sign and the digits, overlapped with the
// next conversion; a stalled output holds the emitter and in turn the converter.
// top level; depends on sitoa_pkg, sitoa_dabble and sitoa_emit
module signed_int_to_decimal_ascii (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: value [VALUE_WIDTH-1:0], zero padding above
	input  logic [sitoa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: char_code [7:0]
	output logic [7:0]                          m_axis_tdata,
	output logic                                m_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready
);
	import sitoa_pkg::*;

	conv_result_t conv_res;
	logic         conv_valid;
	logic         conv_ready;

	// binary to bcd converter
	sitoa_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.value     (s_axis_tdata[VALUE_WIDTH-1:0]),
		.res_valid (conv_valid),
		.res_ready (conv_ready),
		.res       (conv_res)
	);

	// character emitter
	sitoa_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (conv_valid),
		.res_ready (conv_ready),
		.res       (conv_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

FILE: design/sitoa_dabble.sv
// iterative binary to bcd converter using shift and add-3 (double dabble)
// one input bit per cycle through a shared adjust-and-shift unit
// depends on sitoa_pkg
module sitoa_dabble (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sitoa_pkg::VALUE_WIDTH-1:0]   value,
	output logic                                res_valid,
	input  logic                                res_ready,
	output sitoa_pkg::conv_result_t             res
);
	import sitoa_pkg::*;

	conv_state_t             state_q, state_nxt;
	logic [VALUE_WIDTH-1:0]  mag_q;
	logic [BCD_W-1:0]        bcd_q;
	logic                    neg_q;
	logic [SHIFT_CNT_W-1:0]  cnt_q;
	logic [BCD_W-1:0]        bcd_adj;
	logic                    in_neg;
	logic [VALUE_WIDTH-1:0]  in_mag;

	// sign and unsigned magnitude of the incoming value
	assign in_neg = value[VALUE_WIDTH-1];
	assign in_mag = in_neg ? ('0 - value) : value;

	// add 3 to every bcd digit of 5 or more
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			CV_IDLE: begin
				if (in_valid) state_nxt = CV_SHIFT;
			end
			CV_SHIFT: begin
				if (cnt_q == SHIFT_CNT_W'(1)) state_nxt = CV_HOLD;
			end
			CV_HOLD: begin
				if (res_ready) state_nxt = CV_IDLE;
			end
			default: state_nxt = CV_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			CV_IDLE:  in_ready  = 1'b1;
			CV_HOLD:  res_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				res_valid = 1'b0;
			end
		endcase
	end

	assign res.bcd = bcd_q;
	assign res.neg = neg_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == CV_IDLE && in_valid) begin
				cnt_q <= SHIFT_CNT_W'(VALUE_WIDTH);
			end else if (state_q == CV_SHIFT) begin
				cnt_q <= cnt_q - SHIFT_CNT_W'(1);
			end
		end
	end

	// working registers: magnitude shifts out msb first into the bcd digits
	always_ff @(posedge clk) begin
		if (state_q == CV_IDLE && in_valid) begin
			mag_q <= in_mag;
			neg_q <= in_neg;
			bcd_q <= '0;
		end else if (state_q == CV_SHIFT) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end
	end

endmodule

FILE: design/sitoa_emit.sv
// character emitter: drops leading zero digits, sends sign then digits
// through a registered output stage with last on the final character
// depends on sitoa_pkg
module sitoa_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_valid,
	output logic                     res_ready,
	input  sitoa_pkg::conv_result_t  res,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               out_char,
	output logic                     out_last
);
	import sitoa_pkg::*;

	emit_state_t            state_q, state_nxt;
	logic [BCD_W-1:0]       digits_q;
	logic [LEFT_CNT_W-1:0]  left_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;
	logic [3:0]             top_digit;
	logic                   slot_free;
	logic                   top_is_lead_zero;
	logic                   emit_sign;
	logic                   emit_digit;

	assign top_digit        = digits_q[BCD_W-1 -: 4];
	assign slot_free        = !out_valid_q || out_ready;
	assign top_is_lead_zero = (top_digit == 4'd0) && (left_q > LEFT_CNT_W'(1));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			EM_IDLE: begin
				if (res_valid) state_nxt = EM_SKIP;
			end
			EM_SKIP: begin
				if (!top_is_lead_zero) state_nxt = neg_q ? EM_SIGN : EM_DIGIT;
			end
			EM_SIGN: begin
				if (slot_free) state_nxt = EM_DIGIT;
			end
			EM_DIGIT: begin
				if (slot_free && left_q == LEFT_CNT_W'(1)) state_nxt = EM_IDLE;
			end
			default: state_nxt = EM_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		res_ready  = 1'b0;
		emit_sign  = 1'b0;
		emit_digit = 1'b0;
		unique case (state_q)
			EM_IDLE:  res_ready  = 1'b1;
			EM_SIGN:  emit_sign  = slot_free;
			EM_DIGIT: emit_digit = slot_free;
			default: begin
				res_ready  = 1'b0;
				emit_sign  = 1'b0;
				emit_digit = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (emit_sign || emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// digit register shifts up one digit per skipped or sent digit
	always_ff @(posedge clk) begin
		if (state_q == EM_IDLE && res_valid) begin
			digits_q <= res.bcd;
			neg_q    <= res.neg;
			left_q   <= LEFT_CNT_W'(NUM_DIGITS);
		end else if ((state_q == EM_SKIP && top_is_lead_zero) || emit_digit) begin
			digits_q <= {digits_q[BCD_W-5:0], 4'd0};
			left_q   <= left_q - LEFT_CNT_W'(1);
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (emit_sign) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (emit_digit) begin
			out_char_q <= CHAR_ZERO + {4'd0, top_digit};
			out_last_q <= (left_q == LEFT_CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

FILE: design/sitoa_checker.sv
// port-level checker for the signed integer to decimal ascii converter
// bound to the top level; depends on sitoa_pkg
module sitoa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic [7:0]                        m_axis_tdata,
	input logic                              m_axis_tlast,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready
);
	import sitoa_pkg::*;

	// a stalled output item stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item withdrawn while stalled");

	// a stalled output item keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// every character is a minus sign or a decimal digit
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == CHAR_MINUS) ||
			((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE)))
		else $error("output character out of range");

	// a minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast)
		else $error("minus sign flagged as last");

	// a character offered right after an accepted minus sign is not a zero digit
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && (m_axis_tdata == CHAR_MINUS) |=>
			!(m_axis_tvalid && (m_axis_tdata == CHAR_ZERO)))
		else $error("leading zero after minus sign");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
